[rtl/srps_pkg.sv]
// srps_pkg: shared types and constants for the frame statistics block
// word types for both channels, controller states and the command struct
// no dependencies
`default_nettype none

package srps_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int DEF_MAX_SAMPLES = 64;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_word_t;

  typedef struct packed {
    logic        [15:0] rms_value;
    logic signed [15:0] peak_value;
    logic        [15:0] peak_to_peak;
    logic               overflow;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } srps_state_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic out_load;
  } srps_cmd_t;

endpackage

`default_nettype wire

[rtl/srps_ctrl.sv]
// srps_ctrl: sequencer for accumulate, divide, square root and result hand-off
// depends on srps_pkg; drives the srps_dp command struct
`default_nettype none

module srps_ctrl #(
  parameter int MAX_SAMPLES = srps_pkg::DEF_MAX_SAMPLES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output srps_pkg::srps_cmd_t    cmd
);
  import srps_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = 2 * SAMPLE_BITS + CW;
  localparam int CNTW = $clog2(SUMW);

  srps_state_t     state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_ACC: begin
        cnt_nxt = '0;
        if (accept && in_last) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNTW'(SUMW - 1)) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_r == CNTW'(SAMPLE_BITS - 1)) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_ACC: begin
        in_ready = 1'b1;
        cmd.take = accept;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.sqrt_init = (cnt_r == CNTW'(SUMW - 1));
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      ST_FIN: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/srps_dp.sv]
// srps_dp: accumulators, restoring divider, digit-by-digit square root, result register
// depends on srps_pkg; sequenced by srps_ctrl
`default_nettype none

module srps_dp #(
  parameter int MAX_SAMPLES = srps_pkg::DEF_MAX_SAMPLES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire srps_pkg::in_word_t  in_data,
  input  wire srps_pkg::srps_cmd_t cmd,
  output srps_pkg::out_word_t      out_data
);
  import srps_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int MW   = 2 * SAMPLE_BITS;
  localparam int SUMW = MW + CW;

  // frame accumulators
  logic [SUMW-1:0]               sum_r;
  logic signed [SAMPLE_BITS-1:0] max_r, min_r;
  logic [CW-1:0]                 acnt_r;
  logic                          ovf_r;

  logic                          room;
  logic signed [MW-1:0]          sq_s;
  logic [SUMW-1:0]               sum_upd;
  logic signed [SAMPLE_BITS-1:0] max_upd, min_upd;
  logic [CW-1:0]                 acnt_upd;
  logic                          ovf_upd;

  // held frame results
  logic signed [15:0] pk_r;
  logic [15:0]        ptp_r;
  logic               hovf_r;

  // divider
  logic [SUMW-1:0] q_r, q_nxt;
  logic [CW-1:0]   d_r;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [CW:0]     dshift;

  // square root
  logic [SAMPLE_BITS+1:0] srem_r, srem_nxt;
  logic [SAMPLE_BITS-1:0] root_r, root_nxt;
  logic [SAMPLE_BITS+1:0] sshift, trial;

  out_word_t out_r;

  assign room     = acnt_r < CW'(MAX_SAMPLES);
  assign sq_s     = in_data.sample * in_data.sample;

  always_comb begin
    sum_upd  = sum_r;
    max_upd  = max_r;
    min_upd  = min_r;
    acnt_upd = acnt_r;
    ovf_upd  = ovf_r;
    if (room) begin
      sum_upd  = sum_r + SUMW'(unsigned'(sq_s));
      acnt_upd = acnt_r + 1'b1;
      if (acnt_r == '0) begin
        max_upd = in_data.sample;
        min_upd = in_data.sample;
      end else begin
        if (in_data.sample > max_r) max_upd = in_data.sample;
        if (in_data.sample < min_r) min_upd = in_data.sample;
      end
    end else begin
      ovf_upd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      max_r  <= '0;
      min_r  <= '0;
      acnt_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.take) begin
      if (in_data.last_sample) begin
        sum_r  <= '0;
        max_r  <= '0;
        min_r  <= '0;
        acnt_r <= '0;
        ovf_r  <= 1'b0;
      end else begin
        sum_r  <= sum_upd;
        max_r  <= max_upd;
        min_r  <= min_upd;
        acnt_r <= acnt_upd;
        ovf_r  <= ovf_upd;
      end
    end
  end

  // one quotient bit per step
  assign dshift = {rem_r, q_r[SUMW-1]};

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (cmd.div_step) begin
      if (dshift >= {1'b0, d_r}) begin
        rem_nxt = CW'(dshift - {1'b0, d_r});
        q_nxt   = {q_r[SUMW-2:0], 1'b1};
      end else begin
        rem_nxt = dshift[CW-1:0];
        q_nxt   = {q_r[SUMW-2:0], 1'b0};
      end
    end else if (cmd.sqrt_step) begin
      q_nxt = {q_r[SUMW-3:0], 2'b00};
    end
  end

  // one root bit per step, quotient shifts out two bits at a time
  assign sshift = {srem_r[SAMPLE_BITS-1:0], q_r[MW-1:MW-2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    srem_nxt = srem_r;
    root_nxt = root_r;
    if (cmd.sqrt_init) begin
      srem_nxt = '0;
      root_nxt = '0;
    end else if (cmd.sqrt_step) begin
      if (sshift >= trial) begin
        srem_nxt = sshift - trial;
        root_nxt = {root_r[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        srem_nxt = sshift;
        root_nxt = {root_r[SAMPLE_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_data.last_sample) begin
      q_r    <= sum_upd;
      d_r    <= acnt_upd;
      rem_r  <= '0;
      pk_r   <= 16'(max_upd);
      ptp_r  <= 16'(max_upd - min_upd);
      hovf_r <= ovf_upd;
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    if (cmd.out_load) begin
      out_r.rms_value    <= 16'(root_r);
      out_r.peak_value   <= pk_r;
      out_r.peak_to_peak <= ptp_r;
      out_r.overflow     <= hovf_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[rtl/signal_rms_peak_stats.sv]
// signal_rms_peak_stats: top level of the frame rms, peak and span block
// depends on srps_pkg, srps_ctrl and srps_dp
//
// input channel: one signed sample word per accepted in_valid/in_ready
// handshake; last_sample marks the final word of a frame
// output channel: one result word per frame on out_valid/out_ready
// samples of a frame are taken one per cycle; up to MAX_SAMPLES are
// accumulated, later ones only set the overflow flag
// after the last word the block stalls input while the restoring divider
// forms the SUMW-bit quotient one bit per step, SUMW = 2*SAMPLE_BITS +
// clog2(MAX_SAMPLES+1), then the square root unit forms the root one bit
// per step, then the result register is loaded as out_valid rises
// a held result does not block the next frame's accumulation; only the
// hand-off of a new result waits until the old one is taken, and input
// stays stalled while it waits
// reset clears the frame accumulators, the sequencer and out_valid
`default_nettype none

module signal_rms_peak_stats #(
  parameter int MAX_SAMPLES = srps_pkg::DEF_MAX_SAMPLES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire srps_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output srps_pkg::out_word_t      out_data
);
  import srps_pkg::*;

  srps_cmd_t cmd;

  srps_ctrl #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_sample),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  srps_dp #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

[rtl/srps_checker.sv]
// srps_checker: port-level assertions for signal_rms_peak_stats
// depends on srps_pkg; bound to the top level below
`default_nettype none

module srps_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire srps_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire srps_pkg::out_word_t out_data
);
  import srps_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // frame end starts the busy back end
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_sample |=> !in_ready)
    else $error("input taken right after frame end");

  // root never exceeds full-scale magnitude
  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rms_value <= 16'd32768)
    else $error("rms out of range");

endmodule

bind signal_rms_peak_stats srps_checker u_srps_checker (.*);

`default_nettype wire

[dv/srps_frame_checker.sv]
// srps_frame_checker: watches both channels of signal_rms_peak_stats, predicts
// the per-frame rms, peak, span and overflow word and compares it field by field
// depends on srps_pkg

module srps_frame_checker #(
  parameter int MAX_SAMPLES = srps_pkg::DEF_MAX_SAMPLES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  srps_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  srps_pkg::out_word_t out_data,
  output int                  errors,
  output int                  pending
);

  logic [63:0]        acc_sumsq;
  logic signed [15:0] acc_max;
  logic signed [15:0] acc_min;
  int                 acc_count;
  logic               acc_dropped;
  int                 err_cnt;

  srps_pkg::out_word_t results_due[$];

  initial begin
    errors  = 0;
    pending = 0;
    err_cnt = 0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    logic [63:0] rem;
    root = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic clear_frame();
    acc_sumsq   = '0;
    acc_max     = '0;
    acc_min     = '0;
    acc_count   = 0;
    acc_dropped = 1'b0;
  endtask

  task automatic take_sample(input srps_pkg::in_word_t w);
    longint              sv;
    logic [63:0]         root;
    srps_pkg::out_word_t r;
    sv = $signed(w.sample);
    if (acc_count < MAX_SAMPLES) begin
      acc_sumsq = acc_sumsq + 64'(sv * sv);
      if (acc_count == 0) begin
        acc_max = w.sample;
        acc_min = w.sample;
      end else begin
        if (w.sample > acc_max) acc_max = w.sample;
        if (w.sample < acc_min) acc_min = w.sample;
      end
      acc_count++;
    end else begin
      acc_dropped = 1'b1;
    end
    if (w.last_sample) begin
      if (acc_count != 0) begin
        root           = int_sqrt(acc_sumsq / 64'(acc_count));
        r.rms_value    = root[15:0];
        r.peak_value   = acc_max;
        r.peak_to_peak = 16'(acc_max - acc_min);
      end else begin
        r.rms_value    = '0;
        r.peak_value   = '0;
        r.peak_to_peak = '0;
      end
      r.overflow = acc_dropped;
      results_due.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_result(input srps_pkg::out_word_t got);
    srps_pkg::out_word_t want;
    if (results_due.size() == 0) begin
      $error("result word with none expected: rms_value %0d peak_value %0d",
             got.rms_value, $signed(got.peak_value));
      err_cnt++;
    end else begin
      want = results_due.pop_front();
      check_field("rms_value", want.rms_value, got.rms_value);
      check_field("peak_value", $signed(want.peak_value), $signed(got.peak_value));
      check_field("peak_to_peak", want.peak_to_peak, got.peak_to_peak);
      check_field("overflow", want.overflow, got.overflow);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      results_due.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) take_sample(in_data);
    end
    pending <= results_due.size();
    errors  <= err_cnt;
  end

endmodule

[dv/tb_top.sv]
// tb_top: stimulus and verdict for signal_rms_peak_stats
// depends on srps_pkg, signal_rms_peak_stats and srps_frame_checker

module tb_top;

  localparam int MAX_SAMPLES = srps_pkg::DEF_MAX_SAMPLES;
  localparam int PHASE_WORDS = 470;
  localparam int HOLD_CYCLES = 800;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  srps_pkg::in_word_t  in_data   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  srps_pkg::out_word_t out_data;

  int   errors;
  int   pending;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  int   words_sent    = 0;
  logic hold_req      = 1'b0;
  logic holding       = 1'b0;

  signal_rms_peak_stats #(.MAX_SAMPLES(MAX_SAMPLES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  srps_frame_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_frame_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !holding && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !holding) begin
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
        while (hold_req) @(posedge clk);
      end
    end
  end

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] s;
    case ($urandom_range(9))
      0:       s = 16'sh8000;
      1:       s = 16'sh7fff;
      2, 3:    s = 16'($signed($urandom_range(16)) - 8);
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic send_word(input logic signed [15:0] s, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data.sample      <= s;
    in_data.last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_word(pick_sample(), i == len - 1);
  endtask

  function automatic int pick_len();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 70)      len = $urandom_range(8, 1);
    else if (r < 85) len = $urandom_range(63, 9);
    else if (r < 95) len = $urandom_range(MAX_SAMPLES + 2, MAX_SAMPLES - 2);
    else             len = $urandom_range(100, MAX_SAMPLES + 3);
    return len;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames: extremes, full span, small means, alternating bits
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh0000, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh0000, 1'b1);
    send_word(16'sd3, 1'b0);
    send_word(16'sd4, 1'b1);
    send_word(-16'sd5, 1'b0);
    send_word(-16'sd7, 1'b0);
    send_word(-16'sd6, 1'b1);
    send_word(16'sh5555, 1'b0);
    send_word(16'shaaaa, 1'b1);
    drain();

    // input backs up while results are held off
    hold_req <= 1'b1;
    for (int i = 0; i < 8; i++) send_frame($urandom_range(4, 1));
    hold_req <= 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   <= 0;
          out_stall_pct <= 0;
        end
        1: begin
          in_idle_pct   <= 59;
          out_stall_pct <= 0;
        end
        2: begin
          in_idle_pct   <= 0;
          out_stall_pct <= 59;
        end
        default: begin
          in_idle_pct   <= 10;
          out_stall_pct <= 10;
        end
      endcase
      words_sent = 0;
      if (ph == 0) begin
        // frames at and past the sample limit
        send_frame(MAX_SAMPLES);
        send_frame(MAX_SAMPLES + 1);
        send_frame(2 * MAX_SAMPLES + 2);
      end
      while (words_sent < PHASE_WORDS) send_frame(pick_len());
      drain();
    end

    repeat (120) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
